/* rtl/aptbl_pkg.sv */
// aptbl_pkg: shared types and constants for the aging peer table
// table size, action and status codes, entry and beat structs, cell control
// used by aptbl_cell, aptbl_ctrl and aging_peer_table_core
package aptbl_pkg;

  // table geometry
  localparam int TBL_DEPTH = 64;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam int CNT_W     = $clog2(TBL_DEPTH + 1);
  localparam int MISS_W    = 4;

  localparam logic [MISS_W-1:0] MISS_MAX    = 4'd15;
  localparam logic [MISS_W-1:0] LIMIT_RESET = 4'd5;

  // input actions
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_DATE = 2'd1,
    ACT_TIME = 2'd2,
    ACT_READ = 2'd3
  } action_t;

  // result status codes
  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_FULL     = 3'd2;
  localparam logic [2:0] STAT_TICK     = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  // input beat
  typedef struct packed {
    action_t     action;
    logic [31:0] peer_addr;
    logic [5:0]  entry_index;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [6:0]  entry_count;
    logic [6:0]  removed_count;
    logic        entry_valid;
    logic [31:0] out_addr;
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [31:0]       key;
    logic [4:0]        day;
    logic [3:0]        month;
    logic [13:0]       year;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [MISS_W-1:0] misses;
  } entry_t;

  // what moves between neighboring cells
  typedef struct packed {
    logic   dead;
    entry_t ent;
  } cell_io_t;

  // cell operation for the whole row
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_ROTATE,
    CMD_AGE,
    CMD_COMPACT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [MISS_W-1:0] limit;
  } cell_ctl_t;

endpackage

/* rtl/aptbl_cell.sv */
// aptbl_cell: one slot of the peer table row
// holds an entry and its removal mark, takes its right neighbor on shifts
// depends on aptbl_pkg
module aptbl_cell import aptbl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      live,
  input  cell_io_t  nb,
  input  logic      gap_in,
  output cell_io_t  q,
  output logic      gap_out
);

  entry_t            ent_r, ent_nxt;
  logic              dead_r, dead_nxt;
  logic [MISS_W-1:0] miss_inc;

  // saturating missed-tick count
  assign miss_inc = (ent_r.misses == MISS_MAX) ? ent_r.misses : ent_r.misses + 4'd1;

  // a removed slot at or left of here makes this cell shift
  assign gap_out = dead_r | gap_in;

  assign q.dead = dead_r;
  assign q.ent  = ent_r;

  // next contents
  always_comb begin
    ent_nxt  = ent_r;
    dead_nxt = dead_r;
    case (ctl.cmd)
      CMD_ROTATE: begin
        ent_nxt  = nb.ent;
        dead_nxt = nb.dead;
      end
      CMD_AGE: begin
        ent_nxt.misses = miss_inc;
        dead_nxt       = live && (miss_inc >= ctl.limit);
      end
      CMD_COMPACT: begin
        if (gap_out) begin
          ent_nxt  = nb.ent;
          dead_nxt = nb.dead;
        end
      end
      default: begin
        ent_nxt  = ent_r;
        dead_nxt = dead_r;
      end
    endcase
  end

  // entry payload
  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  // removal mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= 1'b0;
    end else begin
      dead_r <= dead_nxt;
    end
  end

endmodule

/* rtl/aptbl_ctrl.sv */
// aptbl_ctrl: sequencer for the peer table row
// scans the head cell as the row rotates, drives aging and compaction, builds results
// depends on aptbl_pkg
module aptbl_ctrl import aptbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          in_data,
  output logic              busy,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MISS_W-1:0] cfg_data,
  input  entry_t            head,
  input  logic              any_dead,
  output cell_io_t          tail,
  output cell_ctl_t         ctl,
  output logic [CNT_W-1:0]  count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_COMPACT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MISS_W-1:0] limit_r, limit_nxt;
  in_item_t          item_r, item_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              found_r, found_nxt;
  logic              ins_r, ins_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  entry_t            rd_r, rd_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              in_use, k_last;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign count     = count_r;

  // head cell position relative to the used part of the table
  assign in_use = (CNT_W'(k_r) < count_r);
  assign k_last = (k_r == IDX_W'(TBL_DEPTH - 1));

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    limit_nxt     = limit_r;
    item_nxt      = item_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    ins_nxt       = ins_r;
    hit_nxt       = hit_r;
    slot_nxt      = slot_r;
    removed_nxt   = removed_r;
    rd_nxt        = rd_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ctl.cmd       = CMD_HOLD;
    ctl.limit     = limit_r;
    tail.dead     = 1'b0;
    tail.ent      = head;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          limit_nxt = cfg_data;
        end
        if (start) begin
          item_nxt    = in_data;
          k_nxt       = '0;
          found_nxt   = 1'b0;
          ins_nxt     = 1'b0;
          hit_nxt     = 1'b0;
          slot_nxt    = '0;
          removed_nxt = '0;
          state_nxt   = (in_data.action == ACT_TICK) ? ST_AGE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        ctl.cmd = CMD_ROTATE;
        k_nxt   = IDX_W'(k_r + 1'b1);
        if (item_r.action == ACT_READ) begin
          // capture the requested slot as it passes the head
          if (k_r == item_r.entry_index && in_use) begin
            hit_nxt = 1'b1;
            rd_nxt  = head;
          end
        end else if (in_use && !found_r && head.key == item_r.peer_addr) begin
          // known peer: refresh the reported field
          found_nxt          = 1'b1;
          slot_nxt           = k_r;
          tail.ent.misses    = '0;
          if (item_r.action == ACT_DATE) begin
            tail.ent.day   = item_r.day;
            tail.ent.month = item_r.month;
            tail.ent.year  = item_r.year;
          end else begin
            tail.ent.hour   = item_r.hour;
            tail.ent.minute = item_r.minute;
            tail.ent.second = item_r.second;
          end
        end else if (CNT_W'(k_r) == count_r && !found_r) begin
          // unknown peer: append at the first free slot
          ins_nxt       = 1'b1;
          slot_nxt      = k_r;
          tail.ent      = '0;
          tail.ent.key  = item_r.peer_addr;
          if (item_r.action == ACT_DATE) begin
            tail.ent.day   = item_r.day;
            tail.ent.month = item_r.month;
            tail.ent.year  = item_r.year;
          end else begin
            tail.ent.hour   = item_r.hour;
            tail.ent.minute = item_r.minute;
            tail.ent.second = item_r.second;
          end
        end

        // full turn done: row is back in place, report
        if (k_last) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (item_r.action == ACT_READ) begin
            out_data_nxt.status      = STAT_READ;
            out_data_nxt.slot        = item_r.entry_index;
            out_data_nxt.entry_count = count_r;
            out_data_nxt.entry_valid = hit_nxt;
            if (hit_nxt) begin
              out_data_nxt.out_addr   = rd_nxt.key;
              out_data_nxt.out_day    = rd_nxt.day;
              out_data_nxt.out_month  = rd_nxt.month;
              out_data_nxt.out_year   = rd_nxt.year;
              out_data_nxt.out_hour   = rd_nxt.hour;
              out_data_nxt.out_minute = rd_nxt.minute;
              out_data_nxt.out_second = rd_nxt.second;
            end
          end else if (found_nxt) begin
            out_data_nxt.status      = STAT_UPDATED;
            out_data_nxt.slot        = slot_nxt;
            out_data_nxt.entry_count = count_r;
          end else if (ins_nxt) begin
            count_nxt                = CNT_W'(count_r + 1'b1);
            out_data_nxt.status      = STAT_INSERTED;
            out_data_nxt.slot        = slot_nxt;
            out_data_nxt.entry_count = CNT_W'(count_r + 1'b1);
          end else begin
            out_data_nxt.status      = STAT_FULL;
            out_data_nxt.entry_count = count_r;
          end
        end
      end

      ST_AGE: begin
        ctl.cmd   = CMD_AGE;
        state_nxt = ST_COMPACT;
      end

      ST_COMPACT: begin
        if (any_dead) begin
          // drop the leftmost marked entry this cycle
          ctl.cmd     = CMD_COMPACT;
          count_nxt   = CNT_W'(count_r - 1'b1);
          removed_nxt = CNT_W'(removed_r + 1'b1);
        end else begin
          state_nxt                  = ST_IDLE;
          out_valid_nxt              = 1'b1;
          out_data_nxt               = '0;
          out_data_nxt.status        = STAT_TICK;
          out_data_nxt.entry_count   = count_r;
          out_data_nxt.removed_count = removed_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      found_r     <= 1'b0;
      ins_r       <= 1'b0;
      hit_r       <= 1'b0;
      removed_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      limit_r     <= limit_nxt;
      found_r     <= found_nxt;
      ins_r       <= ins_nxt;
      hit_r       <= hit_nxt;
      removed_r   <= removed_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      slot_r      <= slot_nxt;
      rd_r        <= rd_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TBL_DEPTH))
    else $error("entry count above table depth");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while still working");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_compact_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMPACT && !any_dead) |=> out_valid_r)
    else $error("tick finished without a result");

  a_found_ins: assert property (@(posedge clk) disable iff (!rst_n)
    !(found_r && ins_r))
    else $error("report both updated and inserted");

endmodule

/* rtl/aging_peer_table_core.sv */
// aging_peer_table_core: top level of the aging peer table
// a row of aptbl_cell slots driven by aptbl_ctrl
// depends on aptbl_pkg, aptbl_cell, aptbl_ctrl
//
// Peer table of up to 64 entries kept as a row of cells that pass entries to
// their left neighbor; the controller sees only the head cell and feeds the
// tail. A date report, time report or read turns the whole row once through
// the head; the result strobe comes as the controller returns to idle, and
// only then is the next start taken. A tick ages every entry at once and then
// removes one expiring entry per cycle; its result comes once no marked entry
// is left. out_valid is high for exactly one cycle per beat and the result must
// be taken then; there is no back pressure. The limit register is written
// through cfg_valid/cfg_ready only while busy is low. Entries are not cleared
// by reset; only slots below the entry count are ever returned.
module aging_peer_table_core import aptbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          in_data,
  output logic              busy,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [MISS_W-1:0] cfg_data
);

  cell_ctl_t              ctl;
  cell_io_t               tail;
  cell_io_t               cell_q [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]   gap_w;
  logic [CNT_W-1:0]       count;

  // sequencer
  aptbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (cell_q[0].ent),
    .any_dead  (gap_w[TBL_DEPTH-1]),
    .tail      (tail),
    .ctl       (ctl),
    .count     (count)
  );

  // row of cells, head at index 0
  for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_cell
    logic     live;
    logic     gap_in;
    cell_io_t nb;

    assign live   = (CNT_W'(i) < count);
    assign gap_in = (i == 0) ? 1'b0 : gap_w[(i == 0) ? 0 : i - 1];
    assign nb     = (i == TBL_DEPTH - 1) ? tail : cell_q[(i == TBL_DEPTH - 1) ? i : i + 1];

    aptbl_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .live    (live),
      .nb      (nb),
      .gap_in  (gap_in),
      .q       (cell_q[i]),
      .gap_out (gap_w[i])
    );
  end

endmodule

/* sim/aging_peer_table_core_tb.sv */
// aging_peer_table_core_tb: self-checking testbench for the aging peer table
// drives reports, ticks and reads, predicts each answer with a behavioral table
// depends on aptbl_pkg and aging_peer_table_core
`timescale 1ns / 1ps

module aging_peer_table_core_tb;
  import aptbl_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic              clk;
  logic              rst_n;
  logic              start;
  in_item_t          in_data;
  logic              busy;
  logic              out_valid;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [MISS_W-1:0] cfg_data;

  // behavioral copy of the peer table
  entry_t            peer_rows [TBL_DEPTH];
  int                rows_used;
  logic [MISS_W-1:0] miss_limit;

  out_item_t awaited_answers [$];

  int  errors;
  int  cycle_count;
  int  items_sent;
  int  status_seen [8];
  int  peak_rows;
  int  peak_removed;
  bit  gaps_on;

  aging_peer_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               awaited_answers.size());
      $display("aging_peer_table_core test failed");
      $finish;
    end
  end

  // position of a peer in the table, -1 when absent
  function automatic int find_peer(input logic [31:0] addr);
    for (int i = 0; i < rows_used; i++) begin
      if (peer_rows[i].key == addr) return i;
    end
    return -1;
  endfunction

  // apply one item to the table copy and work out its answer
  task automatic apply_to_peer_model(input in_item_t it, output out_item_t ans);
    int hit;
    int wr;
    int removed;
    int misses;
    ans = '0;
    case (it.action)
      ACT_TICK: begin
        // age everything, squeeze out expired rows in order
        wr = 0;
        removed = 0;
        for (int rd = 0; rd < rows_used; rd++) begin
          misses = int'(peer_rows[rd].misses);
          if (misses < int'(MISS_MAX)) misses++;
          if (misses >= int'(miss_limit)) begin
            removed++;
          end else begin
            peer_rows[wr] = peer_rows[rd];
            peer_rows[wr].misses = MISS_W'(misses);
            wr++;
          end
        end
        rows_used = wr;
        ans.status = STAT_TICK;
        ans.removed_count = CNT_W'(removed);
      end
      ACT_READ: begin
        ans.status = STAT_READ;
        ans.slot = it.entry_index;
        if (int'(it.entry_index) < rows_used) begin
          ans.entry_valid = 1'b1;
          ans.out_addr    = peer_rows[it.entry_index].key;
          ans.out_day     = peer_rows[it.entry_index].day;
          ans.out_month   = peer_rows[it.entry_index].month;
          ans.out_year    = peer_rows[it.entry_index].year;
          ans.out_hour    = peer_rows[it.entry_index].hour;
          ans.out_minute  = peer_rows[it.entry_index].minute;
          ans.out_second  = peer_rows[it.entry_index].second;
        end
      end
      default: begin
        // date or time report
        hit = find_peer(it.peer_addr);
        if (hit < 0 && rows_used >= TBL_DEPTH) begin
          ans.status = STAT_FULL;
        end else begin
          if (hit < 0) begin
            hit = rows_used;
            peer_rows[hit] = '0;
            peer_rows[hit].key = it.peer_addr;
            rows_used++;
            ans.status = STAT_INSERTED;
          end else begin
            ans.status = STAT_UPDATED;
          end
          if (it.action == ACT_DATE) begin
            peer_rows[hit].day   = it.day;
            peer_rows[hit].month = it.month;
            peer_rows[hit].year  = it.year;
          end else begin
            peer_rows[hit].hour   = it.hour;
            peer_rows[hit].minute = it.minute;
            peer_rows[hit].second = it.second;
          end
          peer_rows[hit].misses = '0;
          ans.slot = IDX_W'(hit);
        end
      end
    endcase
    ans.entry_count = CNT_W'(rows_used);
  endtask

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // result checker: every strobe is one beat
  always @(posedge clk) begin : answer_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_valid) begin
      got = out_data;
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d slot %0d",
                 $time, got.status, got.slot);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        if (got.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.slot !== want.slot) note_mismatch("slot", 64'(want.slot), 64'(got.slot));
        if (got.entry_count !== want.entry_count)
          note_mismatch("entry_count", 64'(want.entry_count), 64'(got.entry_count));
        if (got.removed_count !== want.removed_count)
          note_mismatch("removed_count", 64'(want.removed_count), 64'(got.removed_count));
        if (got.entry_valid !== want.entry_valid)
          note_mismatch("entry_valid", 64'(want.entry_valid), 64'(got.entry_valid));
        if (got.out_addr !== want.out_addr)
          note_mismatch("out_addr", 64'(want.out_addr), 64'(got.out_addr));
        if (got.out_day !== want.out_day)
          note_mismatch("out_day", 64'(want.out_day), 64'(got.out_day));
        if (got.out_month !== want.out_month)
          note_mismatch("out_month", 64'(want.out_month), 64'(got.out_month));
        if (got.out_year !== want.out_year)
          note_mismatch("out_year", 64'(want.out_year), 64'(got.out_year));
        if (got.out_hour !== want.out_hour)
          note_mismatch("out_hour", 64'(want.out_hour), 64'(got.out_hour));
        if (got.out_minute !== want.out_minute)
          note_mismatch("out_minute", 64'(want.out_minute), 64'(got.out_minute));
        if (got.out_second !== want.out_second)
          note_mismatch("out_second", 64'(want.out_second), 64'(got.out_second));
        status_seen[want.status]++;
        if (int'(want.entry_count) > peak_rows) peak_rows = int'(want.entry_count);
        if (int'(want.removed_count) > peak_removed) peak_removed = int'(want.removed_count);
      end
    end
  end

  function automatic in_item_t make_item(input action_t act, input logic [31:0] addr,
                                         input logic [5:0] idx, input logic [4:0] day,
                                         input logic [3:0] month, input logic [13:0] year,
                                         input logic [4:0] hour, input logic [5:0] minute,
                                         input logic [5:0] second);
    in_item_t it;
    it.action      = act;
    it.peer_addr   = addr;
    it.entry_index = idx;
    it.day         = day;
    it.month       = month;
    it.year        = year;
    it.hour        = hour;
    it.minute      = minute;
    it.second      = second;
    return it;
  endfunction

  // date and time fields are random over their full widths
  function automatic in_item_t random_item(input action_t act, input logic [31:0] addr,
                                           input logic [5:0] idx);
    logic [31:0] rnd_date;
    logic [31:0] rnd_clock;
    rnd_date  = $urandom;
    rnd_clock = $urandom;
    return make_item(act, addr, idx, rnd_date[4:0], rnd_date[8:5], rnd_date[22:9],
                     rnd_clock[4:0], rnd_clock[10:5], rnd_clock[16:11]);
  endfunction

  // one command beat, with an occasional gap in front of it
  task automatic send_item(input in_item_t it);
    out_item_t ans;
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 70 : 4)) @(posedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    apply_to_peer_model(it, ans);
    awaited_answers.push_back(ans);
    items_sent++;
  endtask

  // stop issuing and let every answer come back
  task automatic wait_for_idle();
    @(negedge clk);
    start <= 1'b0;
    while (awaited_answers.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MISS_W-1:0] value);
    wait_for_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    miss_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // empty table, field extremes, every action, out of range reads, aging at reset limit
  task automatic test_directed();
    send_item(random_item(ACT_READ, $urandom, 6'd0));
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(make_item(ACT_DATE, 32'h0, 6'h3f, '0, '0, '0, '1, '1, '1));
    send_item(make_item(ACT_TIME, 32'hffff_ffff, 6'h0, '1, '1, '1, '1, '1, '1));
    send_item(make_item(ACT_DATE, 32'hffff_ffff, 6'h0, '1, '1, '1, '0, '0, '0));
    send_item(make_item(ACT_TIME, 32'h0, 6'h3f, '1, '1, '1, '1, '1, '1));
    send_item(random_item(ACT_READ, $urandom, 6'd0));
    send_item(random_item(ACT_READ, $urandom, 6'd1));
    send_item(random_item(ACT_READ, $urandom, 6'd2));
    send_item(random_item(ACT_READ, $urandom, 6'd63));
    repeat (4) send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(make_item(ACT_DATE, 32'h0, 6'h0, 5'd31, 4'd12, 14'd9999, '0, '0, '0));
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(random_item(ACT_READ, $urandom, 6'd0));
    send_item(random_item(ACT_READ, $urandom, 6'd1));
  endtask

  // limit of zero, one and fifteen
  task automatic test_limit_extremes();
    write_limit(4'd0);
    repeat (3) send_item(random_item(ACT_DATE, $urandom, 6'($urandom)));
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(random_item(ACT_READ, $urandom, 6'd0));
    write_limit(4'd1);
    send_item(random_item(ACT_TIME, 32'h1234_5678, 6'($urandom)));
    send_item(random_item(ACT_DATE, 32'h8765_4321, 6'($urandom)));
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    write_limit(4'd15);
    send_item(random_item(ACT_TIME, 32'haaaa_5555, 6'($urandom)));
    send_item(random_item(ACT_DATE, 32'h5555_aaaa, 6'($urandom)));
    for (int t = 0; t < 18; t++) begin
      if (t == 7) send_item(random_item(ACT_TIME, 32'haaaa_5555, 6'($urandom)));
      send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    end
    send_item(random_item(ACT_READ, $urandom, 6'd0));
  endtask

  // fill every slot, then drops, updates while full and one tick that empties it
  task automatic test_table_full();
    logic [31:0] addr;
    write_limit(4'd15);
    while (rows_used < TBL_DEPTH) begin
      do addr = $urandom; while (find_peer(addr) >= 0);
      send_item(random_item(($urandom_range(0, 1) != 0) ? ACT_DATE : ACT_TIME, addr,
                            6'($urandom)));
    end
    repeat (3) begin
      do addr = $urandom; while (find_peer(addr) >= 0);
      send_item(random_item(ACT_TIME, addr, 6'($urandom)));
    end
    send_item(random_item(ACT_DATE, peer_rows[63].key, 6'($urandom)));
    send_item(random_item(ACT_TIME, peer_rows[0].key, 6'($urandom)));
    send_item(random_item(ACT_READ, $urandom, 6'd63));
    send_item(random_item(ACT_READ, $urandom, 6'd0));
    write_limit(4'd1);
    send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
    send_item(random_item(ACT_READ, $urandom, 6'd0));
  endtask

  // random traffic in phases, each with its own limit and set of peers
  task automatic test_random_traffic();
    logic [31:0] peer_pool [$];
    logic [31:0] addr;
    int          roll;
    int          top_idx;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       write_limit(4'd15);
        1:       write_limit(4'd1);
        2:       write_limit(4'd0);
        default: write_limit(MISS_W'($urandom_range(2, 15)));
      endcase
      gaps_on = (ph != 4);
      peer_pool.delete();
      repeat ($urandom_range(8, 96)) peer_pool.push_back($urandom);
      repeat (200) begin
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) addr = $urandom;
        else addr = peer_pool[$urandom_range(0, peer_pool.size() - 1)];
        top_idx = (rows_used > 63) ? 63 : rows_used;
        if (roll < 15) begin
          send_item(random_item(ACT_TICK, $urandom, 6'($urandom)));
        end else if (roll < 45) begin
          send_item(random_item(ACT_DATE, addr, 6'($urandom)));
        end else if (roll < 75) begin
          send_item(random_item(ACT_TIME, addr, 6'($urandom)));
        end else if (roll < 93) begin
          send_item(random_item(ACT_READ, addr, 6'($urandom_range(0, top_idx))));
        end else begin
          send_item(random_item(ACT_READ, addr, 6'($urandom)));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    start       = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    rst_n       = 1'b0;
    errors      = 0;
    cycle_count = 0;
    items_sent  = 0;
    peak_rows   = 0;
    peak_removed = 0;
    gaps_on     = 1'b1;
    rows_used   = 0;
    miss_limit  = LIMIT_RESET;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (peer_rows[i]) peer_rows[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_limit_extremes();
    test_table_full();
    test_random_traffic();

    // drain, then watch for stray strobes
    wait_for_idle();
    repeat (80) @(posedge clk);

    $display("%0d items: %0d updates, %0d inserts, %0d full drops, %0d ticks, %0d reads",
             items_sent, status_seen[STAT_UPDATED], status_seen[STAT_INSERTED],
             status_seen[STAT_FULL], status_seen[STAT_TICK], status_seen[STAT_READ]);
    $display("peak occupancy %0d, most removed by one tick %0d, %0d mismatches",
             peak_rows, peak_removed, errors);
    if (errors == 0) begin
      $display("aging_peer_table_core test passed");
    end else begin
      $display("aging_peer_table_core test failed");
    end
    $finish;
  end

endmodule
